/* hw/rtl/ctt_pkg.sv */
`default_nettype none
package ctt_pkg;
	localparam int unsigned LOG2_SLOTS_DEF   = 12;
	localparam int unsigned CLUSTER_WAYS_DEF = 3;
	localparam int          MATE_SCORE       = 100;
	localparam logic [1:0]  BOUND_NONE       = 2'd0;
	localparam logic [1:0]  BOUND_UPPER      = 2'd1;
	localparam logic [1:0]  BOUND_LOWER      = 2'd2;
	localparam logic [1:0]  BOUND_EXACT      = 2'd3;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_WRITE,
		ST_OUT
	} ctl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic clr_en;
		logic take;
		logic rd_en;
		logic wr_en;
		logic eval_en;
		logic way_rst;
		logic way_inc;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_done;
		logic is_store;
		logic match;
		logic last_way;
	} dp_stat_t;
endpackage
`default_nettype wire

/* hw/rtl/ctt_ram.sv */
`default_nettype none
module ctt_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/ctt_ctrl.sv */
`default_nettype none
module ctt_ctrl
	import ctt_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire dp_stat_t stat,
	output ctl_cmd_t      cmd
);
	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (stat.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.way_rst = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_CHECK;
			end
			ST_CHECK: begin
				// match means free-or-same for a store, key hit for a probe
				if (stat.match || stat.last_way) begin
					cmd.eval_en = 1'b1;
					state_d     = stat.is_store ? ST_WRITE : ST_OUT;
				end else begin
					cmd.way_inc = 1'b1;
					state_d     = ST_READ;
				end
			end
			ST_WRITE: begin
				cmd.wr_en = 1'b1;
				state_d   = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_read_then_check: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |=> state_q == ST_CHECK) else $error("read not checked");
	a_write_store_only: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> stat.is_store) else $error("write on probe");
`endif
endmodule
`default_nettype wire

/* hw/rtl/ctt_dp.sv */
`default_nettype none
module ctt_dp
	import ctt_pkg::*;
#(
	parameter int unsigned LOG2_SLOTS   = LOG2_SLOTS_DEF,
	parameter int unsigned CLUSTER_WAYS = CLUSTER_WAYS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ctl_cmd_t    cmd,
	output dp_stat_t         stat,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        mode,
	input  wire logic [63:0] position_key,
	input  wire logic [7:0]  search_depth,
	input  wire logic [7:0]  ply_count,
	input  wire logic signed [7:0] window_low,
	input  wire logic signed [7:0] window_high,
	input  wire logic signed [7:0] store_value,
	input  wire logic [7:0]  store_move,
	input  wire logic [1:0]  store_flag,
	output logic             hit,
	output logic signed [7:0] score,
	output logic [7:0]       best_move,
	output logic             move_valid,
	output logic             collision
);
	localparam int unsigned SLOTS = (1 << LOG2_SLOTS) + CLUSTER_WAYS - 1;
	localparam int unsigned AW    = $clog2(SLOTS);
	localparam int unsigned WW    = (CLUSTER_WAYS > 1) ? $clog2(CLUSTER_WAYS) : 1;
	localparam logic [WW-1:0] LAST_WAY = WW'(CLUSTER_WAYS - 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(SLOTS - 1);

	logic [7:0]  hed_q;
	logic [AW:0] clr_q;
	logic [WW-1:0] way_q;

	logic        mode_q;
	logic [63:0] key_q;
	logic [7:0]  depth_q, ply_q, move_in_q;
	logic signed [7:0] lo_q, hi_q, val_in_q;
	logic [1:0]  flag_in_q;

	logic [AW-1:0] base, addr, waddr;
	logic [63:0] rkey, rdata, wkey, wdata;
	logic        we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hed_q <= '0;
			clr_q <= '0;
		end else begin
			if (cfg_we) begin
				hed_q <= cfg_data;
			end
			if (cmd.clr_en && !clr_q[AW]) begin
				clr_q <= (clr_q[AW-1:0] == LAST_ADDR) ? {1'b1, {AW{1'b0}}} : clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mode_q    <= mode;
			key_q     <= position_key;
			depth_q   <= search_depth;
			ply_q     <= ply_count;
			lo_q      <= window_low;
			hi_q      <= window_high;
			val_in_q  <= store_value;
			move_in_q <= store_move;
			flag_in_q <= store_flag;
		end
		if (cmd.way_rst) begin
			way_q <= '0;
		end else if (cmd.way_inc) begin
			way_q <= way_q + 1'b1;
		end
	end

	assign base  = AW'(key_q[LOG2_SLOTS-1:0]);
	assign addr  = base + AW'(way_q);
	assign we    = cmd.wr_en || (cmd.clr_en && !clr_q[AW]);
	assign waddr = cmd.wr_en ? addr : clr_q[AW-1:0];
	assign wkey  = cmd.wr_en ? key_q : '0;
	assign wdata = cmd.wr_en ? {key_q[31:0], 6'd0, flag_in_q, move_in_q, val_in_q, depth_q} : '0;

	ctt_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_key (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wkey),
		.re(cmd.rd_en), .raddr(addr), .rdata(rkey)
	);
	ctt_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_data (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.re(cmd.rd_en), .raddr(addr), .rdata(rdata)
	);

	logic st_match, pr_match;
	assign st_match = (rkey == '0) || (rkey == key_q);
	assign pr_match = (rkey == key_q) && (rdata[63:32] == key_q[31:0]);

	assign stat.clr_done = clr_q[AW];
	assign stat.is_store = mode_q;
	assign stat.match    = mode_q ? st_match : pr_match;
	assign stat.last_way = (way_q == LAST_WAY);

	// probe evaluation on the slot just read
	logic [7:0]  edepth, eflag, emove;
	logic signed [7:0] evalue, adj, clamped;
	logic [7:0]  mag;
	logic [9:0]  reach;
	logic        deep, mate_near;
	logic        hit_d, mv_d;
	logic signed [7:0] score_d;

	always_comb begin
		edepth    = rdata[7:0];
		evalue    = rdata[15:8];
		emove     = rdata[23:16];
		eflag     = rdata[31:24];
		mag       = evalue[7] ? 8'(-evalue) : 8'(evalue);
		reach     = 10'(ply_q) + 10'(depth_q) + 10'(hed_q);
		deep      = edepth >= depth_q;
		// add the magnitude on the left so a mate beyond 100 never wraps
		mate_near = (depth_q < edepth) && ((reach + 10'(mag)) < 10'(MATE_SCORE));
		adj       = evalue;
		if (mag > 8'd1 && mate_near) begin
			adj = evalue[7] ? -8'sd1 : 8'sd1;
		end
		if (adj < lo_q) clamped = lo_q;
		else if (hi_q < adj) clamped = hi_q;
		else clamped = adj;
		hit_d   = 1'b0;
		mv_d    = 1'b0;
		score_d = '0;
		if (pr_match) begin
			if (eflag == 8'(BOUND_EXACT)) begin
				mv_d    = 1'b1;
				hit_d   = (mag > 8'd1) ? 1'b1 : deep;
				score_d = clamped;
			end else if (eflag == 8'(BOUND_UPPER)) begin
				hit_d   = deep && (evalue <= lo_q);
				score_d = lo_q;
			end else if (eflag == 8'(BOUND_LOWER)) begin
				hit_d   = deep && (evalue >= hi_q);
				score_d = hi_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval_en) begin
			hit        <= !mode_q && hit_d;
			score      <= mode_q ? 8'sd0 : score_d;
			best_move  <= (!mode_q && pr_match) ? emove : 8'd0;
			move_valid <= !mode_q && mv_d;
			collision  <= mode_q && (rkey != '0) && (rkey != key_q);
		end
	end

`ifndef SYNTHESIS
	a_wr_not_clr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> clr_q[AW]) else $error("store during clear");
	a_way_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.way_inc |-> way_q != LAST_WAY) else $error("way overrun");
	a_clr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q[AW] |=> clr_q[AW]) else $error("clear restarted");
`endif
endmodule
`default_nettype wire

/* hw/rtl/clustered_transposition_table_top.sv */
// Sequence: from input accept, each cluster slot scanned (1..CLUSTER_WAYS)
//   costs a read state and a compare state, stores that write back add a write
//   state, and the result then holds until out_ready.
// Throughput: one item at a time; the next beat is taken the cycle after the
//   result leaves.
// Reset: arst_n clears control and the register; a clearing pass then zeroes
//   all (1<<LOG2_SLOTS)+CLUSTER_WAYS-1 slots, one per cycle, with input held off.
`default_nettype none
module clustered_transposition_table_top
	import ctt_pkg::*;
#(
	parameter int unsigned LOG2_SLOTS   = LOG2_SLOTS_DEF,
	parameter int unsigned CLUSTER_WAYS = CLUSTER_WAYS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        mode,
	input  wire logic [63:0] position_key,
	input  wire logic [7:0]  search_depth,
	input  wire logic [7:0]  ply_count,
	input  wire logic signed [7:0] window_low,
	input  wire logic signed [7:0] window_high,
	input  wire logic signed [7:0] store_value,
	input  wire logic [7:0]  store_move,
	input  wire logic [1:0]  store_flag,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             hit,
	output logic signed [7:0] score,
	output logic [7:0]       best_move,
	output logic             move_valid,
	output logic             collision
);
	ctl_cmd_t cmd;
	dp_stat_t stat;

	ctt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
	);

	ctt_dp #(.LOG2_SLOTS(LOG2_SLOTS), .CLUSTER_WAYS(CLUSTER_WAYS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.mode(mode), .position_key(position_key), .search_depth(search_depth),
		.ply_count(ply_count), .window_low(window_low), .window_high(window_high),
		.store_value(store_value), .store_move(store_move), .store_flag(store_flag),
		.hit(hit), .score(score), .best_move(best_move),
		.move_valid(move_valid), .collision(collision)
	);
endmodule
`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none
module tb_top
	import ctt_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TBL_SLOTS = (1 << LOG2_SLOTS_DEF) + CLUSTER_WAYS_DEF - 1;
	localparam bit MODE_PROBE = 1'b0;
	localparam bit MODE_STORE = 1'b1;
	localparam int KEY_POOL = 24;

	typedef struct packed {
		logic        mode;
		logic [63:0] key;
		logic [7:0]  depth;
		logic [7:0]  ply;
		logic signed [7:0] lo;
		logic signed [7:0] hi;
		logic signed [7:0] val;
		logic [7:0]  mv;
		logic [1:0]  flag;
	} tt_req_t;

	typedef struct packed {
		logic        hit;
		logic signed [7:0] score;
		logic [7:0]  move;
		logic        mvalid;
		logic        coll;
	} tt_resp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic mode = 1'b0;
	logic [63:0] position_key = '0;
	logic [7:0] search_depth = '0, ply_count = '0, store_move = '0;
	logic signed [7:0] window_low = '0, window_high = '0, store_value = '0;
	logic [1:0] store_flag = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic hit, move_valid, collision;
	logic signed [7:0] score;
	logic [7:0] best_move;

	clustered_transposition_table_top uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .mode(mode),
		.position_key(position_key), .search_depth(search_depth),
		.ply_count(ply_count), .window_low(window_low), .window_high(window_high),
		.store_value(store_value), .store_move(store_move), .store_flag(store_flag),
		.out_valid(out_valid), .out_ready(out_ready), .hit(hit), .score(score),
		.best_move(best_move), .move_valid(move_valid), .collision(collision)
	);

	always #4 clk = ~clk;

	logic [63:0] tbl_key [TBL_SLOTS];
	logic [63:0] tbl_data [TBL_SLOTS];
	logic [7:0] horizon = '0;
	logic [63:0] key_pool [KEY_POOL];

	tt_req_t pend_q[$];
	tt_resp_t lookup_q[$];
	int errors = 0;
	int beats_in = 0, beats_out = 0, probe_hits = 0, collisions = 0;

	function automatic tt_resp_t tt_lookup(tt_req_t r);
		tt_resp_t o;
		int b, pos, ed, ev, mag, lo, hi;
		bit found;
		logic [63:0] d;
		o = '0;
		found = 0;
		b = int'(r.key[LOG2_SLOTS_DEF-1:0]);
		if (r.mode == MODE_STORE) begin
			pos = b + CLUSTER_WAYS_DEF - 1;
			for (int w = 0; w < CLUSTER_WAYS_DEF; w++)
				if (!found && (tbl_key[b+w] == 0 || tbl_key[b+w] == r.key)) begin
					pos = b + w;
					found = 1;
				end
			o.coll = tbl_key[pos] != 0 && tbl_key[pos] != r.key;
			tbl_key[pos] = r.key;
			tbl_data[pos] = {r.key[31:0], 6'b0, r.flag, r.mv, r.val, r.depth};
		end else begin
			d = '0;
			for (int w = 0; w < CLUSTER_WAYS_DEF; w++)
				if (!found && tbl_key[b+w] == r.key
						&& tbl_data[b+w][63:32] == r.key[31:0]) begin
					found = 1;
					d = tbl_data[b+w];
				end
			if (found) begin
				ed = int'(d[7:0]);
				ev = int'($signed(d[15:8]));
				lo = int'(r.lo);
				hi = int'(r.hi);
				mag = ev < 0 ? -ev : ev;
				o.move = d[23:16];
				if (d[31:24] == {6'b0, BOUND_EXACT}) begin
					o.mvalid = 1;
					if (mag > 1) begin
						// mate score not reachable in the remaining depth
						if (int'(r.depth) < ed && int'(r.ply) + int'(r.depth)
								+ int'(horizon) < MATE_SCORE - mag)
							ev = ev > 0 ? 1 : -1;
						o.hit = 1;
					end else
						o.hit = ed >= int'(r.depth);
					o.score = ev < lo ? r.lo : (hi < ev ? r.hi : 8'(ev));
				end else if (d[31:24] == {6'b0, BOUND_UPPER}) begin
					o.hit = ed >= int'(r.depth) && ev <= lo;
					o.score = r.lo;
				end else if (d[31:24] == {6'b0, BOUND_LOWER}) begin
					o.hit = ed >= int'(r.depth) && ev >= hi;
					o.score = r.hi;
				end
			end
		end
		return o;
	endfunction

	// sender: bursts with gaps, hold payload until accepted
	int burst_left = 0, gap_left = 0;
	always @(posedge clk) begin
		tt_req_t r;
		if (!(in_valid && !in_ready)) begin
			if (in_valid && in_ready) begin
				r = '{mode, position_key, search_depth, ply_count, window_low,
					window_high, store_value, store_move, store_flag};
				lookup_q.push_back(tt_lookup(r));
				beats_in++;
			end
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pend_q.size() > 0) begin
				r = pend_q.pop_front();
				in_valid <= 1'b1;
				mode <= r.mode;
				position_key <= r.key;
				search_depth <= r.depth;
				ply_count <= r.ply;
				window_low <= r.lo;
				window_high <= r.hi;
				store_value <= r.val;
				store_move <= r.mv;
				store_flag <= r.flag;
				if (burst_left > 0)
					burst_left--;
				else begin
					if ($urandom_range(0, 4) == 0) begin
						burst_left = 150;
						gap_left = 0;
					end else begin
						burst_left = $urandom_range(0, 15);
						gap_left = $urandom_range(0, 7);
					end
				end
			end else
				in_valid <= 1'b0;
		end
	end

	// receiver: random stall styles, one long hold-off
	int cyc = 0, stall_style = 0, hold_left = 0;
	bit held = 0;
	always @(posedge clk) begin
		tt_resp_t e;
		cyc++;
		if (out_valid && out_ready) begin
			beats_out++;
			if (lookup_q.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				e = lookup_q.pop_front();
				if (hit !== e.hit) begin
					$error("hit exp %0d got %0d", e.hit, hit); errors++;
				end
				if (score !== e.score) begin
					$error("score exp %0d got %0d", e.score, score); errors++;
				end
				if (best_move !== e.move) begin
					$error("best_move exp %0d got %0d", e.move, best_move); errors++;
				end
				if (move_valid !== e.mvalid) begin
					$error("move_valid exp %0d got %0d", e.mvalid, move_valid); errors++;
				end
				if (collision !== e.coll) begin
					$error("collision exp %0d got %0d", e.coll, collision); errors++;
				end
				probe_hits += e.hit;
				collisions += e.coll;
			end
		end
		if (!held && beats_out == 700) begin
			held = 1;
			hold_left = 400;
		end
		if (cyc % 64 == 0)
			stall_style = $urandom_range(0, 2);
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (stall_style == 0)
			out_ready <= 1'b1;
		else if (stall_style == 1)
			out_ready <= $urandom_range(0, 2) != 0;
		else
			out_ready <= $urandom_range(0, 3) == 0;
	end

	task automatic add_item(bit m, logic [63:0] k, logic [7:0] dp, logic [7:0] pl,
			logic signed [7:0] lo, logic signed [7:0] hi, logic signed [7:0] v,
			logic [7:0] mv, logic [1:0] fl);
		pend_q.push_back('{m, k, dp, pl, lo, hi, v, mv, fl});
	endtask

	function automatic logic [7:0] pick_val();
		case ($urandom_range(0, 4))
			0: return 8'($urandom_range(0, 3) - 1);
			1: return 8'($urandom_range(90, 127));
			2: return 8'(-$urandom_range(90, 128));
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic add_random();
		logic [63:0] k;
		logic [7:0] dp, pl;
		k = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom}
			: key_pool[$urandom_range(0, KEY_POOL - 1)];
		dp = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
		pl = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
		add_item($urandom_range(0, 1), k, dp, pl, pick_val(), pick_val(), pick_val(),
			8'($urandom), 2'($urandom));
	endtask

	task automatic write_horizon(logic [7:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		horizon = v;
	endtask

	task automatic wait_drained();
		while (pend_q.size() > 0 || in_valid || lookup_q.size() > 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	initial begin
		logic [63:0] ka, kb, kc, kd;
		int base;
		for (int i = 0; i < TBL_SLOTS; i++) begin
			tbl_key[i] = '0;
			tbl_data[i] = '0;
		end
		// few clusters, some overlapping, the top one included
		for (int i = 0; i < KEY_POOL; i++) begin
			case (i % 6)
				0: base = 0;
				1: base = 4095;
				2: base = 100;
				3: base = 101;
				4: base = 102;
				default: base = 2000;
			endcase
			key_pool[i] = {$urandom, $urandom};
			key_pool[i][LOG2_SLOTS_DEF-1:0] = base[LOG2_SLOTS_DEF-1:0];
		end
		key_pool[0] = '0;
		key_pool[7] = '1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		write_horizon(8'd0);

		ka = 64'h0123_4567_89ab_c500;
		kb = 64'hfedc_ba98_7654_3500;
		kc = 64'h5555_aaaa_5555_a500;
		kd = 64'haaaa_5555_aaaa_5500;
		add_item(MODE_PROBE, '0, 0, 0, -128, 127, 0, 0, BOUND_NONE);
		add_item(MODE_PROBE, ka, 0, 0, -128, 127, 0, 0, BOUND_NONE);
		add_item(MODE_STORE, ka, 20, 0, 0, 0, 127, 8'hff, BOUND_EXACT);
		add_item(MODE_PROBE, ka, 3, 5, -128, 127, 0, 0, BOUND_NONE);
		add_item(MODE_PROBE, ka, 3, 255, -128, 127, 0, 0, BOUND_NONE);
		add_item(MODE_STORE, kb, 255, 0, 0, 0, -128, 8'h5a, BOUND_EXACT);
		add_item(MODE_STORE, kc, 5, 0, 0, 0, -1, 8'h01, BOUND_EXACT);
		add_item(MODE_STORE, kd, 5, 0, 0, 0, 40, 8'h80, BOUND_LOWER);
		add_item(MODE_PROBE, kb, 0, 0, 10, -10, 0, 0, BOUND_NONE);
		add_item(MODE_PROBE, kc, 5, 0, 0, 127, 0, 0, BOUND_NONE);
		add_item(MODE_PROBE, kc, 6, 0, -128, 127, 0, 0, BOUND_NONE);
		add_item(MODE_PROBE, kd, 5, 0, -5, 30, 0, 0, BOUND_NONE);
		add_item(MODE_PROBE, kd, 5, 0, -5, 50, 0, 0, BOUND_NONE);
		add_item(MODE_STORE, kc, 7, 0, 0, 0, -20, 8'h33, BOUND_UPPER);
		add_item(MODE_PROBE, kc, 7, 0, -10, 0, 0, 0, BOUND_NONE);
		add_item(MODE_PROBE, kc, 7, 0, -30, 0, 0, 0, BOUND_NONE);
		add_item(MODE_STORE, '1, 1, 0, 0, 0, 0, 8'h11, BOUND_NONE);
		add_item(MODE_PROBE, '1, 0, 0, -1, 1, 0, 0, BOUND_NONE);
		add_item(MODE_PROBE, kd ^ 64'h1_0000_0000, 0, 0, 0, 0, 0, 0, BOUND_NONE);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_horizon(8'd0);
				1: write_horizon(8'd255);
				2: write_horizon(8'($urandom));
				default: write_horizon(8'd60);
			endcase
			for (int i = 0; i < 470; i++)
				add_random();
			wait_drained();
		end

		$display("covered %0d beats in, %0d results, %0d probe hits, %0d collisions",
			beats_in, beats_out, probe_hits, collisions);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#4ms;
		$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire
